/* design/kalman_cv_tracker_2state_macros.svh */
// ----------------------------------------------------------------------------
// kalman_cv_tracker_2state assertion macros
// Concurrent assertion wrappers clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KALMAN_CV_TRACKER_2STATE_MACROS_SVH
`define KALMAN_CV_TRACKER_2STATE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define KCV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("kcv assertion failed");

`define KCV_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("kcv forbidden condition seen");

`else

`define KCV_ASSERT(lbl, prop)

`define KCV_NEVER(lbl, expr)

`endif

`endif

/* design/kcv_pkg.sv */
// ----------------------------------------------------------------------------
// kcv_pkg
// Shared widths, operation codes and controller/datapath command bundle.
// ----------------------------------------------------------------------------
package kcv_pkg;

  localparam int DataW = 32;
  localparam int FracW = 16;
  localparam int QuoW  = DataW + FracW;   // divider dividend/quotient width
  localparam int CntW  = $clog2(QuoW);
  localparam int OpW   = 5;

  // configuration register indexes
  localparam logic [2:0] CFG_TIME_STEP = 3'd0;
  localparam logic [2:0] CFG_PROC_NOISE = 3'd1;
  localparam logic [2:0] CFG_MEAS_NOISE = 3'd2;
  localparam logic [2:0] CFG_INIT_POS = 3'd3;
  localparam logic [2:0] CFG_INIT_VEL = 3'd4;
  localparam logic [2:0] CFG_INIT_VAR = 3'd5;

  // micro-operations, issued in this order for a measurement
  typedef enum logic [OpW-1:0] {
    OP_DT2, OP_DT3, OP_DT4, OP_Q00, OP_Q01, OP_Q11,
    OP_X0, OP_A00, OP_A01, OP_P00, OP_P01, OP_P11,
    OP_K0, OP_K1, OP_E, OP_POS, OP_VEL, OP_G, OP_H,
    OP_B00, OP_B01, OP_B10, OP_B11, OP_KR0, OP_KR1,
    OP_ACC0, OP_CPP, OP_ACC1, OP_CPV, OP_ACC2, OP_CVV
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_WR, ST_DONE
  } state_t;

  typedef struct packed {
    logic start;      // capture measurement, clear clip flag
    logic restart;    // reload state from configuration
    logic mul;        // product register load / divider load
    logic div_step;   // one restoring divide step
    logic wr;         // round, accumulate, saturate, write destination
    logic load_out;   // move state into output register
    op_t  op;
  } cmd_t;

endpackage

/* design/kcv_ctrl.sv */
// ----------------------------------------------------------------------------
// kcv_ctrl
// Sequencer: walks the micro-operation list, times the serial divider.
// ----------------------------------------------------------------------------
`include "kalman_cv_tracker_2state_macros.svh"

module kcv_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tuser,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output kcv_pkg::cmd_t cmd
);
  import kcv_pkg::*;

  state_t              state, state_next;
  op_t                 op, op_next;
  logic [CntW-1:0]     cnt, cnt_next;
  logic                is_div;
  logic                accept;
  logic                out_free;
  logic [5:0]          strobes;

  assign is_div   = (op == OP_K0) || (op == OP_K1);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign strobes  = {cmd.start, cmd.restart, cmd.mul, cmd.div_step, cmd.wr, cmd.load_out};

  always_comb begin
    state_next = state;
    op_next    = op;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_next    = OP_DT2;
          state_next = s_tuser ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        cnt_next   = '0;
        state_next = is_div ? ST_DIV : ST_WR;
      end
      ST_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CntW'(QuoW - 1)) state_next = ST_WR;
      end
      ST_WR: begin
        if (op == OP_CVV) begin
          state_next = ST_DONE;
        end else begin
          op_next    = op_t'(op + 1'b1);
          state_next = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = op;
    cmd.start    = (state == ST_IDLE) && accept && !s_tuser;
    cmd.restart  = (state == ST_IDLE) && accept && s_tuser;
    cmd.mul      = (state == ST_MUL);
    cmd.div_step = (state == ST_DIV);
    cmd.wr       = (state == ST_WR);
    cmd.load_out = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op       <= OP_DT2;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      cnt   <= cnt_next;
      if (cmd.load_out)  m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  `KCV_ASSERT(a_cmd_onehot, $onehot0(strobes))
  `KCV_ASSERT(a_load_free, cmd.load_out |-> out_free)
  `KCV_ASSERT(a_accept_busy, accept |=> state != ST_IDLE)
  `KCV_ASSERT(a_div_then_wr, (state == ST_DIV && cnt == CntW'(QuoW - 1)) |=> state == ST_WR)

endmodule

/* design/kcv_dp.sv */
// ----------------------------------------------------------------------------
// kcv_dp
// Datapath: config registers, filter state, one shared multiplier,
// restoring divider, round/saturate/accumulate unit, output register.
// ----------------------------------------------------------------------------
`include "kalman_cv_tracker_2state_macros.svh"

module kcv_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  kcv_pkg::cmd_t              cmd,
  input  logic [kcv_pkg::DataW-1:0]  s_tdata,
  input  logic                       cfg_valid,
  input  logic [2:0]                 cfg_index,
  input  logic [kcv_pkg::DataW-1:0]  cfg_data,
  output logic [127:0]               m_tdata,
  output logic                       m_tuser
);
  import kcv_pkg::*;

  localparam logic signed [DataW-1:0] MaxV = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] MinV = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] One  = DataW'(1) <<< FracW;
  localparam int SumW = DataW + 4;

  // configuration
  logic [16:0]             time_step;
  logic [30:0]             process_noise, measurement_noise, initial_variance;
  logic signed [DataW-1:0] initial_position, initial_velocity;

  // filter state and scratch
  logic signed [DataW-1:0] pos, vel, cpp, cpv, cvv, z;
  logic signed [DataW-1:0] dt2, dt3, dt4, q00, q01, q11, x0, a00, a01;
  logic signed [DataW-1:0] p00, p01, p11, k0, k1, e, g, h;
  logic signed [DataW-1:0] b00, b01, b10, b11, kr0, kr1;
  logic signed [DataW+2:0] acc;
  logic                    clip;

  logic signed [DataW-1:0] dt, qn, rn;
  assign dt = DataW'(time_step);
  assign qn = DataW'(process_noise);
  assign rn = DataW'(measurement_noise);

  // operand selection
  logic signed [DataW-1:0] a_op, b_op, num;
  logic signed [DataW+2:0] x_op, y_op;
  logic [1:0]              sh;
  always_comb begin
    a_op = '0; b_op = '0; x_op = '0; y_op = '0; sh = 2'd0;
    num  = (cmd.op == OP_K0) ? p00 : p01;
    case (cmd.op)
      OP_DT2:  begin a_op = dt;  b_op = dt;  end
      OP_DT3:  begin a_op = dt2; b_op = dt;  end
      OP_DT4:  begin a_op = dt2; b_op = dt2; end
      OP_Q00:  begin a_op = qn;  b_op = dt4; sh = 2'd2; end
      OP_Q01:  begin a_op = qn;  b_op = dt3; sh = 2'd1; end
      OP_Q11:  begin a_op = qn;  b_op = dt;  end
      OP_X0:   begin a_op = dt;  b_op = vel; x_op = 35'(pos); end
      OP_A00:  begin a_op = dt;  b_op = cpv; x_op = 35'(cpp); end
      OP_A01:  begin a_op = dt;  b_op = cvv; x_op = 35'(cpv); end
      OP_P00:  begin a_op = dt;  b_op = a01; x_op = 35'(a00); y_op = 35'(q00); end
      OP_P01:  begin x_op = 35'(a01); y_op = 35'(q01); end
      OP_P11:  begin x_op = 35'(cvv); y_op = 35'(q11); end
      OP_E:    begin x_op = 35'(z); y_op = -35'(x0); end
      OP_POS:  begin a_op = k0; b_op = e; x_op = 35'(x0); end
      OP_VEL:  begin a_op = k1; b_op = e; x_op = 35'(vel); end
      OP_G:    begin x_op = 35'(One); y_op = -35'(k0); end
      OP_H:    begin x_op = -35'(k1); end
      OP_B00:  begin a_op = g; b_op = p00; end
      OP_B01:  begin a_op = g; b_op = p01; end
      OP_B10:  begin a_op = h; b_op = p00; x_op = 35'(p01); end
      OP_B11:  begin a_op = h; b_op = p01; x_op = 35'(p11); end
      OP_KR0:  begin a_op = k0; b_op = rn; end
      OP_KR1:  begin a_op = k1; b_op = rn; end
      OP_ACC0: begin a_op = g; b_op = b00; end
      OP_CPP:  begin a_op = kr0; b_op = k0; y_op = acc; end
      OP_ACC1: begin a_op = b00; b_op = h; end
      OP_CPV:  begin a_op = kr0; b_op = k1; x_op = 35'(b01); y_op = acc; end
      OP_ACC2: begin a_op = b10; b_op = h; end
      OP_CVV:  begin a_op = kr1; b_op = k1; x_op = 35'(b11); y_op = acc; end
      default: begin a_op = '0; b_op = '0; end
    endcase
  end

  // multiplier: magnitudes, product registered
  logic [DataW-1:0]   ma, mb, mn;
  logic [2*DataW-1:0] preg;
  logic               pneg;
  assign ma = a_op[DataW-1] ? DataW'(-a_op) : DataW'(a_op);
  assign mb = b_op[DataW-1] ? DataW'(-b_op) : DataW'(b_op);
  assign mn = num[DataW-1] ? DataW'(-num) : DataW'(num);

  // divider: S = P00 + r
  logic signed [DataW+1:0] s_full;
  logic                    s_pos;
  logic [QuoW-1:0]         dq;
  logic [DataW-1:0]        rem;
  logic                    dneg;
  logic [DataW:0]          rsh;
  logic                    ge;
  assign s_full = 34'(p00) + 34'(signed'({1'b0, measurement_noise}));
  assign s_pos  = !s_full[DataW+1] && (s_full != '0);
  assign rsh    = {rem, dq[QuoW-1]};
  assign ge     = rsh >= {1'b0, s_full[DataW-1:0]};

  // round, saturate to data range, accumulate
  logic [2*DataW-1:0]      rnd;
  logic [QuoW-1:0]         mag, lim, magc;
  logic                    neg, is_div, mclip;
  logic signed [DataW+1:0] m;
  logic signed [SumW-1:0]  sum;
  logic signed [DataW-1:0] res, res_sh;
  logic                    sclip, neg_var, wclip;
  always_comb begin
    is_div = (cmd.op == OP_K0) || (cmd.op == OP_K1);
    rnd    = preg + (2*DataW)'(1 << (FracW - 1));
    mag    = is_div ? dq : rnd[FracW +: QuoW];
    neg    = is_div ? dneg : pneg;
    lim    = neg ? QuoW'(1) << (DataW - 1) : (QuoW'(1) << (DataW - 1)) - 1'b1;
    mclip  = mag > lim;
    magc   = mclip ? lim : mag;
    m      = neg ? -signed'({1'b0, magc[DataW:0]}) : signed'({1'b0, magc[DataW:0]});
    if (is_div && !s_pos) begin
      m     = '0;
      mclip = 1'b0;
    end
    sum   = SumW'(m) + SumW'(x_op) + SumW'(y_op);
    sclip = 1'b0;
    if (sum > SumW'(MaxV)) begin
      res = MaxV; sclip = 1'b1;
    end else if (sum < SumW'(MinV)) begin
      res = MinV; sclip = 1'b1;
    end else begin
      res = sum[DataW-1:0];
    end
    res_sh  = res >>> sh;
    neg_var = ((cmd.op == OP_CPP) || (cmd.op == OP_CVV)) && res[DataW-1];
    wclip   = mclip || sclip || neg_var;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step         <= 17'd6554;
      process_noise     <= 31'd3277;
      measurement_noise <= 31'd32768;
      initial_position  <= '0;
      initial_velocity  <= 32'sd32768;
      initial_variance  <= 31'd655360;
      pos  <= '0;
      vel  <= 32'sd32768;
      cpp  <= 32'sd655360;
      cvv  <= 32'sd655360;
      cpv  <= '0;
      clip <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TIME_STEP:  time_step         <= cfg_data[16:0];
          CFG_PROC_NOISE: process_noise     <= cfg_data[30:0];
          CFG_MEAS_NOISE: measurement_noise <= cfg_data[30:0];
          CFG_INIT_POS:   initial_position  <= cfg_data;
          CFG_INIT_VEL:   initial_velocity  <= cfg_data;
          CFG_INIT_VAR:   initial_variance  <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (cmd.restart) begin
        pos  <= initial_position;
        vel  <= initial_velocity;
        cpp  <= DataW'(initial_variance);
        cvv  <= DataW'(initial_variance);
        cpv  <= '0;
        clip <= 1'b0;
      end
      if (cmd.start) clip <= 1'b0;
      if (cmd.wr) begin
        if (wclip) clip <= 1'b1;
        case (cmd.op)
          OP_POS: pos <= res;
          OP_VEL: vel <= res;
          OP_CPP: cpp <= neg_var ? '0 : res;
          OP_CPV: cpv <= res;
          OP_CVV: cvv <= neg_var ? '0 : res;
          default: ;
        endcase
      end
    end
  end

  // scratch, product and divider registers (no reset needed)
  always_ff @(posedge clk) begin
    if (cmd.start) z <= s_tdata;
    if (cmd.mul) begin
      preg <= ma * mb;
      pneg <= a_op[DataW-1] ^ b_op[DataW-1];
      dq   <= {mn, FracW'(0)};
      rem  <= '0;
      dneg <= num[DataW-1];
    end
    if (cmd.div_step) begin
      rem <= ge ? DataW'(rsh - {1'b0, s_full[DataW-1:0]}) : rsh[DataW-1:0];
      dq  <= {dq[QuoW-2:0], ge};
    end
    if (cmd.wr) begin
      case (cmd.op)
        OP_DT2:  dt2 <= res;
        OP_DT3:  dt3 <= res;
        OP_DT4:  dt4 <= res;
        OP_Q00:  q00 <= res_sh;
        OP_Q01:  q01 <= res_sh;
        OP_Q11:  q11 <= res;
        OP_X0:   x0  <= res;
        OP_A00:  a00 <= res;
        OP_A01:  a01 <= res;
        OP_P00:  p00 <= res;
        OP_P01:  p01 <= res;
        OP_P11:  p11 <= res;
        OP_K0:   k0  <= res;
        OP_K1:   k1  <= res;
        OP_E:    e   <= res;
        OP_G:    g   <= res;
        OP_H:    h   <= res;
        OP_B00:  b00 <= res;
        OP_B01:  b01 <= res;
        OP_B10:  b10 <= res;
        OP_B11:  b11 <= res;
        OP_KR0:  kr0 <= res;
        OP_KR1:  kr1 <= res;
        OP_ACC0, OP_ACC1, OP_ACC2: acc <= sum[DataW+2:0];
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      m_tdata <= {2'b00, cvv[30:0], cpp[30:0], vel, pos};
      m_tuser <= clip;
    end
  end

  `KCV_NEVER(a_cpp_nonneg, cpp[DataW-1])
  `KCV_NEVER(a_cvv_nonneg, cvv[DataW-1])
  `KCV_ASSERT(a_neg_var_clip, (cmd.wr && neg_var) |=> clip)

endmodule

/* design/kalman_cv_tracker_2state.sv */
// ----------------------------------------------------------------------------
// kalman_cv_tracker_2state
// Two-state constant-velocity Kalman filter, scalar position measurement,
// signed Q16.16 throughout, Joseph-form covariance update.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: measurement; s_tuser: action
//  m_*      out  m_tvalid/m_tready  m_tdata: pos, vel, P00, P11; m_tuser: sat
//  cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A measurement beat runs 31 micro-ops, each as an operand/multiply step and
// a write step, on the one shared 32x32 multiplier; the two gain divisions add
// a pass through the one-bit-per-cycle restoring divider. A restart beat goes
// straight to the done state. Reset is synchronous; it restores the register
// defaults and the initial filter state, no clearing pass.
// The result sits in an output register; a new input beat is taken while it
// waits, and the sequencer stalls only at the end of the next item.
// cfg_ready is always high; write registers only while the block is idle.
module kalman_cv_tracker_2state (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [31:0] measurement
  input  logic         s_tuser,   // [0] action: 0 update, 1 restart
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // [31:0] position_estimate,
                                  // [63:32] velocity_estimate,
                                  // [94:64] position_variance,
                                  // [125:95] velocity_variance, [127:126] 0
  output logic         m_tuser,   // [0] saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import kcv_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  // sequencer
  kcv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // arithmetic, state and output register
  kcv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
